// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// ===== hdl/smi_pkg.sv =====
`default_nettype none

package smi_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_ATOMS_DEFAULT  = 6;
   localparam int WORD_WIDTH_DEFAULT = 64;

   // Fixed port widths.
   localparam int WEIGHT_WIDTH   = 64;
   localparam int COEF_WIDTH     = 64;
   localparam int INDEX_WIDTH    = 6;
   localparam int ATOM_CNT_WIDTH = 3;

   // Reset value of the atom count register.
   localparam logic [ATOM_CNT_WIDTH-1:0] ATOM_COUNT_RESET = 3'd6;

endpackage

`default_nettype wire

// ===== hdl/smi_store.sv =====
`default_nettype none

module smi_store #(
   parameter int ADDR_WIDTH = smi_pkg::MAX_ATOMS_DEFAULT,
   parameter int DATA_WIDTH = smi_pkg::WORD_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr_a,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr_b,
   output logic      [DATA_WIDTH-1:0] rd_data_a,
   output logic      [DATA_WIDTH-1:0] rd_data_b
);

   localparam int Depth = 1 << ADDR_WIDTH;

   logic [DATA_WIDTH-1:0] mem [Depth];
   logic [DATA_WIDTH-1:0] rd_a_ff;
   logic [DATA_WIDTH-1:0] rd_b_ff;

   // One write port and two registered read ports; read data holds while
   // no read is enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== hdl/subset_mobius_inversion_core.sv =====
// Loading accepts weights back to back. The inversion runs n passes, one per
// dimension, each issuing that dimension's pairs and then a gap state, through one
// shared subtractor fed by two store read ports. Emission gives one coefficient per
// cycle while the receiver does not stall. Synchronous active-high reset clears the
// control state and sets the atom count to 6; the store is not cleared.
`default_nettype none

module subset_mobius_inversion_core #(
   parameter int MAX_ATOMS  = smi_pkg::MAX_ATOMS_DEFAULT,
   parameter int WORD_WIDTH = smi_pkg::WORD_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Configuration write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [smi_pkg::ATOM_CNT_WIDTH-1:0]  csr_atom_count,
   // Weight input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [smi_pkg::WEIGHT_WIDTH-1:0]    req_weight,
   // Coefficient output channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [smi_pkg::COEF_WIDTH-1:0]      rsp_coefficient,
   output logic      [smi_pkg::INDEX_WIDTH-1:0]     rsp_subset_index,
   output logic                                     rsp_last_out
);

   `include "assert_macros.svh"

   localparam int AW     = MAX_ATOMS;
   localparam int NW     = $clog2(MAX_ATOMS + 1);
   localparam int CoefW  = smi_pkg::COEF_WIDTH;
   localparam int IndexW = smi_pkg::INDEX_WIDTH;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_INV,
      ST_GAP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [smi_pkg::ATOM_CNT_WIDTH-1:0] atom_ff;
   logic [AW:0]   load_cnt_ff, load_cnt_in;
   logic [NW-1:0] dim_ff, dim_in;
   logic [AW-1:0] pair_ff, pair_in;
   logic [AW-1:0] emit_ff, emit_in;
   logic          wr_valid_ff, wr_valid_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_index_ff, rsp_index_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [NW-1:0] n_act;
   logic [AW:0]   run_len;
   logic [AW-1:0] bit_j;
   logic [AW-1:0] low_mask;
   logic [AW-1:0] pair_addr;
   logic          load_fire;
   logic          run_full;
   logic          issue;
   logic          last_pair;
   logic          last_dim;
   logic          emit_go;
   logic          emit_last;
   logic          rsp_taken;

   logic                  st_wr_en;
   logic [AW-1:0]         st_wr_addr;
   logic [WORD_WIDTH-1:0] st_wr_data;
   logic                  st_rd_en;
   logic [AW-1:0]         st_rd_addr_a;
   logic [AW-1:0]         st_rd_addr_b;
   logic [WORD_WIDTH-1:0] st_rd_data_a;
   logic [WORD_WIDTH-1:0] st_rd_data_b;

   // Active dimension count saturates at MAX_ATOMS, the store address width.
   assign n_act   = (atom_ff > smi_pkg::ATOM_CNT_WIDTH'(MAX_ATOMS)) ?
                    NW'(MAX_ATOMS) : NW'(atom_ff);
   assign run_len = (AW + 1)'(1) << n_act;

   // Pair p of dimension j addresses the entry with bit j inserted as one.
   assign bit_j     = AW'(1) << dim_ff;
   assign low_mask  = bit_j - AW'(1);
   assign pair_addr = ((pair_ff & ~low_mask) << 1) | bit_j | (pair_ff & low_mask);

   assign load_fire = req_valid && !req_stall;
   assign run_full  = (load_cnt_ff + (AW + 1)'(1)) >= run_len;
   assign rsp_taken = rsp_valid_ff && !rsp_stall;
   assign issue     = (state_ff == ST_INV) && !rsp_valid_ff;
   assign last_pair = pair_ff == AW'((run_len >> 1) - (AW + 1)'(1));
   assign last_dim  = dim_ff == NW'(n_act - NW'(1));
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign emit_last = emit_ff == AW'(run_len - (AW + 1)'(1));

   // Store port steering: loads and subtract write-backs never overlap.
   always_comb begin
      st_wr_en     = 1'b0;
      st_wr_addr   = load_cnt_ff[AW-1:0];
      st_wr_data   = req_weight[WORD_WIDTH-1:0];
      st_rd_en     = issue || emit_go;
      st_rd_addr_a = emit_ff;
      st_rd_addr_b = emit_ff;
      if (load_fire) begin
         st_wr_en = 1'b1;
      end else if (wr_valid_ff) begin
         st_wr_en   = 1'b1;
         st_wr_addr = wr_addr_ff;
         st_wr_data = st_rd_data_a - st_rd_data_b;
      end
      if (state_ff == ST_INV) begin
         st_rd_addr_a = pair_addr;
         st_rd_addr_b = pair_addr ^ bit_j;
      end
   end

   smi_store #(
      .ADDR_WIDTH (AW),
      .DATA_WIDTH (WORD_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (st_wr_en),
      .wr_addr   (st_wr_addr),
      .wr_data   (st_wr_data),
      .rd_en     (st_rd_en),
      .rd_addr_a (st_rd_addr_a),
      .rd_addr_b (st_rd_addr_b),
      .rd_data_a (st_rd_data_a),
      .rd_data_b (st_rd_data_b)
   );

   // Sequencer next state: load, invert dimension by dimension if any, then emit.
   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      dim_in       = dim_ff;
      pair_in      = pair_ff;
      emit_in      = emit_ff;
      wr_valid_in  = issue;
      wr_addr_in   = pair_addr;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (load_fire) begin
               if (run_full) begin
                  load_cnt_in = '0;
                  dim_in      = '0;
                  pair_in     = '0;
                  emit_in     = '0;
                  state_in    = (n_act == '0) ? ST_EMIT : ST_INV;
               end else begin
                  load_cnt_in = load_cnt_ff + (AW + 1)'(1);
               end
            end
         end
         ST_INV: begin
            if (issue) begin
               if (last_pair) begin
                  pair_in  = '0;
                  state_in = ST_GAP;
               end else begin
                  pair_in = pair_ff + AW'(1);
               end
            end
         end
         ST_GAP: begin
            // The last write of this pass lands here before the next pass reads.
            if (last_dim) begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end else begin
               dim_in   = dim_ff + NW'(1);
               state_in = ST_INV;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = emit_ff;
               rsp_last_in  = emit_last;
               if (emit_last) begin
                  state_in = ST_LOAD;
               end else begin
                  emit_in = emit_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State, counters and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         atom_ff      <= smi_pkg::ATOM_COUNT_RESET;
         load_cnt_ff  <= '0;
         dim_ff       <= '0;
         pair_ff      <= '0;
         emit_ff      <= '0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         dim_ff       <= dim_in;
         pair_ff      <= pair_in;
         emit_ff      <= emit_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            atom_ff <= csr_atom_count;
         end
      end
      wr_addr_ff   <= wr_addr_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Port drive.
   assign csr_ready        = 1'b1;
   assign req_stall        = state_ff != ST_LOAD;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coefficient  = CoefW'(st_rd_data_a);
   assign rsp_subset_index = IndexW'(rsp_index_ff);
   assign rsp_last_out     = rsp_last_ff;

   // A weight write and a subtract write-back must never meet.
   `ASSERT_NEVER(a_no_write_clash, clock, reset, load_fire && wr_valid_ff)
   // The gap cycle drains the write-back before the next pass reads.
   `ASSERT_HOLDS(a_gap_drains, clock, reset, (state_ff == ST_GAP) |=> !wr_valid_ff)
   // Emission never starts with a write-back still pending.
   `ASSERT_HOLDS(a_emit_clean, clock, reset, (state_ff == ST_EMIT) |-> !wr_valid_ff)

endmodule

`default_nettype wire

// ===== tb/sv/tb_subset_mobius_inversion_core.sv =====
`timescale 1ns / 1ps

module tb_subset_mobius_inversion_core;

   localparam int MAX_ATOMS     = smi_pkg::MAX_ATOMS_DEFAULT;
   localparam int SETTLE_CYCLES = 300;
   localparam int TIMEOUT_NS    = 10_000_000;
   localparam int PRINT_LIMIT   = 30;

   typedef logic [smi_pkg::WEIGHT_WIDTH-1:0]   word_type;
   typedef logic [smi_pkg::ATOM_CNT_WIDTH-1:0] atoms_type;

   typedef struct packed {
      logic [smi_pkg::COEF_WIDTH-1:0]  coefficient;
      logic [smi_pkg::INDEX_WIDTH-1:0] subset_index;
      logic                            last_out;
   } coef_result_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_style_type;
   typedef enum {W_ZERO, W_ONES, W_ONE_HOT, W_SMALL, W_NEAR_TOP} weight_kind_type;

   logic      clock            = 1'b0;
   logic      reset            = 1'b1;
   logic      csr_valid        = 1'b0;
   logic      csr_ready;
   atoms_type csr_atom_count   = '0;
   logic      req_valid        = 1'b0;
   logic      req_stall;
   word_type  req_weight       = '0;
   logic      rsp_valid;
   logic      rsp_stall        = 1'b0;
   logic [smi_pkg::COEF_WIDTH-1:0]  rsp_coefficient;
   logic [smi_pkg::INDEX_WIDTH-1:0] rsp_subset_index;
   logic                            rsp_last_out;

   // Shadow of the block's state, kept by the predictor.
   word_type        weight_mirror [64];
   logic [6:0]      loaded_weights = '0;
   atoms_type       atom_setting   = smi_pkg::ATOM_COUNT_RESET;
   coef_result_type expected_coefs [$];

   int mismatch_count = 0;
   int burst_left     = 0;
   int hold_request   = 0;

   subset_mobius_inversion_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_atom_count   (csr_atom_count),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_weight       (req_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_subset_index (rsp_subset_index),
      .rsp_last_out     (rsp_last_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   // Store one weight; on the last weight of a run, invert the lattice in place and
   // queue every coefficient of the run in index order.
   task automatic predict_coefficients(input word_type w);
      int unsigned active;
      int unsigned run_len;
      int          j;
      int          k;
      coef_result_type r;
      active  = (atom_setting > MAX_ATOMS) ? MAX_ATOMS : atom_setting;
      run_len = 1 << active;
      weight_mirror[loaded_weights[5:0]] = w;
      loaded_weights = loaded_weights + 7'd1;
      if (loaded_weights < run_len)
         return;
      for (j = 0; j < active; j++) begin
         for (k = 0; k < run_len; k++) begin
            if ((k >> j) & 1)
               weight_mirror[k] = weight_mirror[k] - weight_mirror[k ^ (1 << j)];
         end
      end
      for (k = 0; k < run_len; k++) begin
         r.coefficient  = weight_mirror[k];
         r.subset_index = k[smi_pkg::INDEX_WIDTH-1:0];
         r.last_out     = (k + 1 == run_len);
         expected_coefs = {expected_coefs, r};
      end
      loaded_weights = '0;
   endtask

   // Mostly full random words, with the edges of the word mixed in.
   function automatic word_type rand_weight();
      weight_kind_type kind;
      if ($urandom_range(0, 2) != 0)
         return {$urandom, $urandom};
      kind = weight_kind_type'($urandom_range(0, 4));
      case (kind)
         W_ZERO:     return '0;
         W_ONES:     return '1;
         W_ONE_HOT:  return word_type'(1) << $urandom_range(0, smi_pkg::WEIGHT_WIDTH - 1);
         W_SMALL:    return word_type'($urandom_range(0, 15));
         default:    return '1 - word_type'($urandom_range(0, 15));
      endcase
   endfunction

   // Send one weight transaction; the sender works in bursts with random gaps.
   task automatic send_weight(input word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid  <= 1'b1;
      req_weight <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      burst_left--;
      predict_coefficients(w);
   endtask

   // Pause the sender until every expected coefficient is out and the block is quiet.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_coefs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_atom_count(input atoms_type value);
      csr_valid      <= 1'b1;
      csr_atom_count <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      atom_setting = value;
   endtask

   // Whole runs of random weights at one atom count.
   task automatic send_random_runs(input atoms_type atoms, input int items);
      int run_len;
      int runs;
      wait_until_idle();
      write_atom_count(atoms);
      run_len = 1 << ((atoms > MAX_ATOMS) ? MAX_ATOMS : atoms);
      runs    = (items / run_len > 0) ? items / run_len : 1;
      repeat (runs * run_len) send_weight(rand_weight());
   endtask

   // The atom count must come out of reset at its full value.
   task automatic test_reset_default();
      repeat (64) send_weight(rand_weight());
   endtask

   // With no dimensions every weight is a run of its own and passes unchanged.
   task automatic test_single_weight_runs();
      wait_until_idle();
      write_atom_count(3'd0);
      send_weight('0);
      send_weight('1);
      send_weight(64'h8000_0000_0000_0000);
      send_weight(64'h5555_5555_5555_5555);
   endtask

   // One dimension: differences that wrap around the word in both directions.
   task automatic test_wraparound_pairs();
      wait_until_idle();
      write_atom_count(3'd1);
      send_weight('1);
      send_weight('0);
      send_weight('0);
      send_weight(64'd1);
      send_weight(64'd1);
      send_weight('0);
   endtask

   task automatic test_four_entry_lattice();
      wait_until_idle();
      write_atom_count(3'd2);
      send_weight('1);
      send_weight(64'h0123_4567_89ab_cdef);
      send_weight(64'haaaa_aaaa_aaaa_aaaa);
      send_weight(64'h5555_5555_5555_5555);
   endtask

   // Lowering the count in a partly loaded run ends the run at the new length;
   // once below the loaded count, once above it.
   task automatic test_count_lowered_mid_run();
      wait_until_idle();
      write_atom_count(3'd3);
      send_weight(rand_weight());
      send_weight(rand_weight());
      wait_until_idle();
      write_atom_count(3'd2);
      send_weight(rand_weight());
      send_weight(rand_weight());
      wait_until_idle();
      write_atom_count(3'd3);
      repeat (5) send_weight(rand_weight());
      wait_until_idle();
      write_atom_count(3'd1);
      send_weight(rand_weight());
   endtask

   // A count above the maximum behaves as the maximum.
   task automatic test_count_saturation();
      send_random_runs(3'd7, 64);
   endtask

   task automatic test_random_sizes();
      send_random_runs(3'd0, 24);
      send_random_runs(3'd1, 24);
      send_random_runs(3'd3, 16);
      send_random_runs(3'd4, 16);
      send_random_runs(3'd2, 24);
   endtask

   // The receiver holds off long enough that the block fills and stalls its input.
   task automatic test_output_backpressure();
      wait_until_idle();
      write_atom_count(3'd5);
      hold_request = 700;
      repeat (64) send_weight(rand_weight());
   endtask

   task automatic test_largest_runs();
      send_random_runs(3'd6, 64);
   endtask

   // Receiver stall pattern: styles change on their own, and a long hold can be requested.
   always @(posedge clock) begin : coef_stall_gen
      static int              hold_left   = 0;
      static int              style_left  = 0;
      static stall_style_type style       = STALL_NONE;
      static logic [7:0]      stall_shape = 8'h00;
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (style_left == 0) begin
            style       = stall_style_type'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 200);
            stall_shape = 8'($urandom);
         end
         style_left--;
         case (style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: begin
               stall_shape = {stall_shape[6:0], stall_shape[7]};
               rsp_stall <= stall_shape[0];
            end
         endcase
      end
   end

   // Compare each accepted coefficient transaction with the oldest expectation.
   always @(posedge clock) begin : coef_checker
      coef_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_coefs.size() == 0) begin
            report_mismatch("coefficient with nothing expected", rsp_coefficient, '0);
         end else begin
            want = expected_coefs.pop_front();
            if (rsp_coefficient !== want.coefficient)
               report_mismatch("coefficient", rsp_coefficient, want.coefficient);
            if (rsp_subset_index !== want.subset_index)
               report_mismatch("subset_index", word_type'(rsp_subset_index),
                               word_type'(want.subset_index));
            if (rsp_last_out !== want.last_out)
               report_mismatch("last_out", word_type'(rsp_last_out),
                               word_type'(want.last_out));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_default();
      test_single_weight_runs();
      test_wraparound_pairs();
      test_four_entry_lattice();
      test_count_lowered_mid_run();
      test_count_saturation();
      test_random_sizes();
      test_output_backpressure();
      test_largest_runs();
      wait_until_idle();
      if (expected_coefs.size() != 0)
         report_mismatch("coefficients never delivered", word_type'(0),
                         word_type'(expected_coefs.size()));
      if (mismatch_count == 0)
         $display("tb_subset_mobius_inversion_core passed");
      else
         $display("tb_subset_mobius_inversion_core failed");
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("tb_subset_mobius_inversion_core failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/smi_pkg.sv
hdl/smi_store.sv
hdl/subset_mobius_inversion_core.sv
tb/sv/tb_subset_mobius_inversion_core.sv
